### rtl/core/ptbl_pkg.sv
// ----------------------------------------------------------------------------
// Token bucket limiter package
// Shared constants, function codes and the sequencer-to-datapath command.
// ----------------------------------------------------------------------------
package ptbl_pkg;

    localparam int DEF_ENTRIES  = 64;
    localparam int DEF_KEY_BITS = 32;

    localparam int TOK_W  = 31;
    localparam int TIME_W = 32;
    localparam int COST_W = 16;
    localparam int IKEY_W = 32;

    localparam logic [TOK_W-1:0] CAP_DEFAULT  = 31'd100;
    localparam logic [TOK_W-1:0] RATE_DEFAULT = 31'd10;

    // Function codes of an input item.
    localparam logic [1:0] FUNC_CONSUME = 2'd0;
    localparam logic [1:0] FUNC_QUERY   = 2'd1;
    localparam logic [1:0] FUNC_CLEAR   = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_MAX_TOKENS  = 1'b0;
    localparam logic CFG_REFILL_RATE = 1'b1;

    // Operation requested of the shared arithmetic unit.
    typedef enum logic [1:0] {
        ALU_DIFF = 2'd0,
        ALU_MUL  = 2'd1,
        ALU_ADD  = 2'd2,
        ALU_SUB  = 2'd3
    } alu_op_t;

    typedef struct packed {
        logic    en;
        alu_op_t op;
    } alu_cmd_t;

endpackage

### rtl/core/ptbl_alu.sv
// ----------------------------------------------------------------------------
// Token bucket shared arithmetic unit
// One registered adder/subtracter or 32x32 multiplier, chosen per step.
// ----------------------------------------------------------------------------
module ptbl_alu
(
    input  logic                   clk,
    input  ptbl_pkg::alu_cmd_t     cmd,
    input  logic [31:0]            op_a,
    input  logic [31:0]            op_b,
    output logic [63:0]            result
);
    import ptbl_pkg::*;

    logic [63:0] result_reg;
    logic [63:0] result_next;

    // Select one operation per cycle.
    always_comb
    begin
        unique case (cmd.op)
            ALU_DIFF: result_next = {32'd0, op_a - op_b};
            ALU_MUL:  result_next = {32'd0, op_a} * {32'd0, op_b};
            ALU_ADD:  result_next = {32'd0, op_a} + {32'd0, op_b};
            ALU_SUB:  result_next = {32'd0, op_a - op_b};
            default:  result_next = 64'd0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.en)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

### rtl/core/per_client_token_bucket_limiter.sv
// ----------------------------------------------------------------------------
// Per-client token bucket limiter
// Looks up a client bucket, refills it by elapsed time and consumes tokens.
// ----------------------------------------------------------------------------
// Clear, unused-code or absent-key items skip the lookup and go straight to the output step.
// A lookup scans one table entry per cycle until a key match or the end of the used entries.
// The scan over the bucket memory sets the rate; one item is in work at a time.
// Reset clears the fill count and returns the configuration registers to their defaults.
// The result register frees the input the cycle after the result is taken.
module per_client_token_bucket_limiter
#(
    parameter int ENTRIES  = ptbl_pkg::DEF_ENTRIES,
    parameter int KEY_BITS = ptbl_pkg::DEF_KEY_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic        key_present,
    input  logic [31:0] client_key,
    input  logic [31:0] now_seconds,
    input  logic [15:0] cost,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        allowed,
    output logic [30:0] remaining,
    output logic [1:0]  retry_after,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [30:0] cfg_data
);
    import ptbl_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int KW    = (KEY_BITS < IKEY_W) ? KEY_BITS : IKEY_W;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCAN  = 4'd1;
    localparam logic [3:0] S_PICK  = 4'd2;
    localparam logic [3:0] S_RD    = 4'd3;
    localparam logic [3:0] S_DIFF  = 4'd4;
    localparam logic [3:0] S_MUL   = 4'd5;
    localparam logic [3:0] S_ADD   = 4'd6;
    localparam logic [3:0] S_SUB   = 4'd7;
    localparam logic [3:0] S_WB    = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    // Bucket memory: key, tokens and time stamp per entry.
    logic [KW-1:0]     mem_key  [ENTRIES];
    logic [TOK_W-1:0]  mem_tok  [ENTRIES];
    logic [TIME_W-1:0] mem_time [ENTRIES];

    logic [3:0]        state_reg, state_next;
    logic [CNT_W-1:0]  used_reg;
    logic [TOK_W-1:0]  cap_reg, rate_reg;
    logic [1:0]        func_reg;
    logic [KW-1:0]     key_reg;
    logic [TIME_W-1:0] now_reg;
    logic [COST_W-1:0] cost_reg;
    logic [CNT_W-1:0]  scan_reg;
    logic [IDX_W-1:0]  slot_reg, old_idx_reg;
    logic [TIME_W-1:0] old_time_reg;
    logic              found_reg, fresh_reg;
    logic [KW-1:0]     rd_key_reg;
    logic [TOK_W-1:0]  tok_reg;
    logic [TIME_W-1:0] rd_time_reg;
    logic              rd_ok_reg;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic [TIME_W-1:0] diff_reg;
    logic              allowed_reg;
    logic [TOK_W-1:0]  remaining_reg;
    logic [1:0]        retry_reg;
    logic              out_valid_reg;

    logic [TOK_W-1:0]  cap_eff, rate_eff;
    alu_cmd_t          cmd;
    logic [31:0]       op_a, op_b;
    logic [63:0]       alu_res;
    logic [COST_W-1:0] cost_eff;
    logic              in_acc;

    assign cap_eff  = (cap_reg == '0) ? CAP_DEFAULT : cap_reg;
    assign rate_eff = (rate_reg == '0) ? RATE_DEFAULT : rate_reg;
    assign cost_eff = (cost_reg == '0) ? COST_W'(1) : cost_reg;
    assign in_ready = (state_reg == S_IDLE) && !out_valid_reg;
    assign in_acc   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    // Shared unit command per step.
    always_comb
    begin
        cmd.en = 1'b0;
        cmd.op = ALU_DIFF;
        op_a   = now_reg;
        op_b   = tok_reg == '0 ? rd_time_reg : rd_time_reg;
        unique case (state_reg)
            S_DIFF:
            begin
                cmd.en = 1'b1;
                cmd.op = ALU_DIFF;
                op_a   = now_reg;
                op_b   = rd_time_reg;
            end
            S_MUL:
            begin
                cmd.en = 1'b1;
                cmd.op = ALU_MUL;
                op_a   = alu_res[31:0];
                op_b   = {1'b0, rate_eff};
            end
            S_ADD:
            begin
                cmd.en = 1'b1;
                cmd.op = ALU_ADD;
                op_a   = {1'b0, tok_reg};
                op_b   = (alu_res[63:31] != '0) ? 32'h7FFF_FFFF : alu_res[31:0];
            end
            S_SUB:
            begin
                cmd.en = 1'b1;
                cmd.op = ALU_SUB;
                op_a   = {1'b0, tok_reg};
                op_b   = {16'd0, cost_eff};
            end
            default:
            begin
                cmd.en = 1'b0;
            end
        endcase
    end

    ptbl_alu u_alu
    (
        .clk    (clk),
        .cmd    (cmd),
        .op_a   (op_a),
        .op_b   (op_b),
        .result (alu_res)
    );

    // Sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    if ((func == FUNC_CONSUME || func == FUNC_QUERY) && key_present)
                        state_next = S_SCAN;
                    else
                        state_next = S_OUT;
                end
            end
            S_SCAN:
            begin
                if (rd_ok_reg && rd_key_reg == key_reg)
                    state_next = S_RD;
                else if (scan_reg >= used_reg && !rd_ok_reg)
                    state_next = S_PICK;
            end
            S_PICK:  state_next = S_RD;
            S_RD:    state_next = S_DIFF;
            S_DIFF:  state_next = S_MUL;
            S_MUL:   state_next = S_ADD;
            S_ADD:   state_next = S_SUB;
            S_SUB:   state_next = S_WB;
            S_WB:    state_next = S_OUT;
            S_OUT:   state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            used_reg      <= '0;
            cap_reg       <= CAP_DEFAULT;
            rate_reg      <= RATE_DEFAULT;
            out_valid_reg <= 1'b0;
            rd_ok_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                if (cfg_index == CFG_MAX_TOKENS)
                    cap_reg <= cfg_data;
                else
                    rate_reg <= cfg_data;
            end
            if (in_acc && func == FUNC_CLEAR)
                used_reg <= '0;
            if (state_reg == S_PICK && !found_reg && used_reg < CNT_W'(ENTRIES))
                used_reg <= used_reg + 1'b1;
            // Read pipeline valid: one entry read per cycle while scanning.
            rd_ok_reg <= (state_reg == S_SCAN) && (scan_reg < used_reg)
                         && !(rd_ok_reg && rd_key_reg == key_reg);
            if (state_reg == S_OUT)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers and memory.
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            func_reg     <= func;
            key_reg      <= KW'(client_key);
            now_reg      <= now_seconds;
            cost_reg     <= cost;
            scan_reg     <= '0;
            found_reg    <= 1'b0;
            old_idx_reg  <= '0;
            old_time_reg <= '1;
            fresh_reg    <= 1'b0;
            allowed_reg  <= 1'b1;
            remaining_reg <= cap_eff;
            retry_reg    <= 2'd0;
        end
        // Scan: read one entry per cycle, compare the previous one.
        if (state_reg == S_SCAN)
        begin
            if (scan_reg < used_reg)
            begin
                rd_key_reg  <= mem_key[scan_reg[IDX_W-1:0]];
                rd_time_reg <= mem_time[scan_reg[IDX_W-1:0]];
                rd_idx_reg  <= scan_reg[IDX_W-1:0];
                scan_reg    <= scan_reg + 1'b1;
            end
            if (rd_ok_reg)
            begin
                if (rd_key_reg == key_reg)
                begin
                    found_reg <= 1'b1;
                    slot_reg  <= rd_idx_reg;
                end
                else if (rd_time_reg < old_time_reg || rd_idx_reg == '0)
                begin
                    old_time_reg <= rd_time_reg;
                    old_idx_reg  <= rd_idx_reg;
                end
            end
        end
        // Choose a new slot: next free entry, else the oldest.
        if (state_reg == S_PICK)
        begin
            fresh_reg <= 1'b1;
            if (used_reg < CNT_W'(ENTRIES))
                slot_reg <= used_reg[IDX_W-1:0];
            else
                slot_reg <= old_idx_reg;
        end
        // Read the bucket (a new bucket is full, stamped now).
        if (state_reg == S_RD)
        begin
            if (fresh_reg)
            begin
                tok_reg     <= cap_eff;
                rd_time_reg <= now_reg;
                mem_key[slot_reg] <= key_reg;
            end
            else
            begin
                tok_reg     <= mem_tok[slot_reg];
                rd_time_reg <= mem_time[slot_reg];
            end
        end
        if (state_reg == S_MUL)
            diff_reg <= alu_res[31:0];
        // Refill: add, cap, stamp only for positive elapsed time.
        if (state_reg == S_SUB)
        begin
            if (diff_reg != '0 && !diff_reg[31])
            begin
                tok_reg     <= (alu_res[32:0] > {2'd0, cap_eff}) ? cap_eff : alu_res[30:0];
                rd_time_reg <= now_reg;
            end
        end
        // Consume and write back.
        if (state_reg == S_WB)
        begin
            mem_time[slot_reg] <= rd_time_reg;
            if (func_reg == FUNC_CONSUME && tok_reg >= TOK_W'(cost_eff))
            begin
                mem_tok[slot_reg] <= tok_reg - TOK_W'(cost_eff);
                allowed_reg   <= 1'b1;
                remaining_reg <= tok_reg - TOK_W'(cost_eff);
                retry_reg     <= (tok_reg != TOK_W'(cost_eff)) ? 2'd0
                               : ((rate_eff == TOK_W'(1)) ? 2'd2 : 2'd1);
            end
            else
            begin
                mem_tok[slot_reg] <= tok_reg;
                allowed_reg   <= (func_reg == FUNC_QUERY) && (tok_reg != '0);
                remaining_reg <= tok_reg;
                retry_reg     <= (tok_reg != '0) ? 2'd0
                               : ((rate_eff == TOK_W'(1)) ? 2'd2 : 2'd1);
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign allowed     = allowed_reg;
    assign remaining   = remaining_reg;
    assign retry_after = retry_reg;

    // The fill count never exceeds the table depth.
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CNT_W'(ENTRIES)) else $error("fill count overflow");
    // No item is accepted while a result waits.
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !in_ready) else $error("accept while result pending");
    // A result follows the output step.
    a_out_after: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_OUT |=> out_valid_reg) else $error("result lost");

endmodule
